// File: rtl/snfcs_pkg.sv
package snfcs_pkg;

  typedef enum logic [3:0] {
    K_READ   = 4'd0,
    K_FREAD  = 4'd1,
    K_PROG   = 4'd2,
    K_ERASE  = 4'd3,
    K_ID     = 4'd4,
    K_STATUS = 4'd5,
    K_RESET  = 4'd6,
    K_REPLY  = 4'd7,
    K_DATA   = 4'd8
  } kind_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_HDR, PH_RDATA, PH_NEED, PH_PDATA, PH_WREN, PH_POLLCMD,
    PH_POLLBYTE, PH_WRDI, PH_ID, PH_STCMD, PH_STBYTE, PH_RSTEN, PH_RST
  } phase_t;

  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_FREAD = 8'h0B;
  localparam logic [7:0] OP_PROG  = 8'h02;
  localparam logic [7:0] OP_ERASE = 8'h20;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_WRDI  = 8'h04;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_RDID  = 8'h9F;
  localparam logic [7:0] OP_RSTEN = 8'h66;
  localparam logic [7:0] OP_RST   = 8'h99;
  localparam logic [7:0] FILLER   = 8'hFF;

  typedef struct packed {
    logic [3:0]  kind;
    logic [23:0] address;
    logic [24:0] length;
    logic [7:0]  write_byte;
    logic [7:0]  reply_byte;
  } item_t;

  typedef struct packed {
    logic        spi_valid;
    logic [7:0]  spi_byte;
    logic        frame_end;
    logic        read_valid;
    logic [23:0] read_data;
    logic        need_data;
    logic        done_res;
    logic        last;
  } res_t;

  typedef struct packed {
    logic  req;
    logic  reply;
    logic  data;
    item_t it;
  } cls_t;

endpackage

// File: rtl/snfcs_if.sv
interface snfcs_in_if import snfcs_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface snfcs_out_if import snfcs_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/snfcs_front.sv
module snfcs_front import snfcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_data,
  output logic  q_valid,
  input  logic  q_ready,
  output cls_t  q_data
);

  cls_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       push, pop;
  cls_t       c;

  always_comb begin
    c.it    = in_data;
    c.req   = in_data.kind <= K_RESET;
    c.reply = in_data.kind == K_REPLY;
    c.data  = in_data.kind == K_DATA;
  end

  assign in_ready = cnt_r != 3'd4;
  assign push     = in_valid && in_ready && (c.req || c.reply || c.data);
  assign q_valid  = cnt_r != 3'd0;
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule

// File: rtl/snfcs_back.sv
module snfcs_back import snfcs_pkg::*; #(
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096,
  parameter int ADDRESS_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  cls_t q_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  localparam int PB = $clog2(PAGE_BYTES);
  localparam int SB = $clog2(SECTOR_BYTES);
  localparam logic [23:0] AMASK = 24'((33'd1 << ADDRESS_BITS) - 33'd1);

  phase_t      ph_r, ph_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [23:0] ca_r, ca_nxt;
  logic [24:0] bl_r, bl_nxt;
  logic [10:0] cl_r, cl_nxt;
  logic [2:0]  hi_r, hi_nxt;
  logic [23:0] id_r, id_nxt;
  logic [23:0] sn_r, sn_nxt, sf_r, sf_nxt;

  res_t        o0_r, o1_r;
  logic [1:0]  oc_r;
  res_t        r0, r1;
  logic [1:0]  n;
  logic        take;

  assign q_ready   = oc_r == 2'd0 || (oc_r == 2'd1 && out_ready);
  assign take      = q_valid && q_ready;
  assign out_valid = oc_r != 2'd0;
  assign out_data  = o0_r;

  function automatic res_t spi(input logic [7:0] b, input logic e);
    res_t r;
    r = '0; r.spi_valid = 1'b1; r.spi_byte = b; r.frame_end = e;
    return r;
  endfunction

  function automatic res_t rd(input logic [23:0] v);
    res_t r;
    r = '0; r.read_valid = 1'b1; r.read_data = v;
    return r;
  endfunction

  function automatic res_t dn();
    res_t r;
    r = '0; r.done_res = 1'b1;
    return r;
  endfunction

  function automatic res_t nd();
    res_t r;
    r = '0; r.need_data = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [2:0] i, input logic [3:0] op,
                                          input logic [23:0] a);
    logic [7:0] b;
    unique case (i)
      3'd0: b = op == K_READ ? OP_READ : op == K_FREAD ? OP_FREAD :
                op == K_PROG ? OP_PROG : OP_ERASE;
      3'd1: b = a[23:16];
      3'd2: b = a[15:8];
      3'd3: b = a[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic hdr_end(input logic [2:0] i, input logic [3:0] op,
                                   input logic [24:0] bl);
    logic fin;
    fin = ({1'b0, i} + 4'd1) == (op == K_FREAD ? 4'd5 : 4'd4);
    return fin && (op == K_ERASE || (op <= K_FREAD && bl == '0));
  endfunction

  logic [23:0] addr_m, ca_p1, room_a;
  logic [25:0] endsum;
  logic [23:0] endc;
  logic [10:0] room;
  logic [2:0]  hlen;
  logic [7:0]  rb;
  cls_t        d;

  always_comb begin
    d      = q_data;
    rb     = d.it.reply_byte;
    addr_m = d.it.address & AMASK;
    endsum = {2'b0, addr_m} + {1'b0, d.it.length} - 26'd1;
    endc   = endsum > {2'b0, AMASK} ? AMASK : endsum[23:0];
    ca_p1  = (ca_r + 24'd1) & AMASK;
    hlen   = op_r == K_FREAD ? 3'd5 : 3'd4;
  end

  always_comb begin
    ph_nxt = ph_r; op_nxt = op_r; ca_nxt = ca_r; bl_nxt = bl_r; cl_nxt = cl_r;
    hi_nxt = hi_r; id_nxt = id_r; sn_nxt = sn_r; sf_nxt = sf_r;
    r0 = '0; r1 = '0; n = 2'd0;
    room_a = '0; room = '0;
    if (take) begin
      if (d.req && ph_r == PH_IDLE) begin
        op_nxt = d.it.kind;
        n = 2'd1;
        unique case (d.it.kind)
          K_READ, K_FREAD: begin
            ca_nxt = addr_m; bl_nxt = d.it.length; hi_nxt = '0;
            r0 = spi(hdr_byte(3'd0, d.it.kind, addr_m),
                     hdr_end(3'd0, d.it.kind, d.it.length));
            ph_nxt = PH_HDR;
          end
          K_PROG: begin
            ca_nxt = addr_m; bl_nxt = d.it.length;
            if (d.it.length == '0) r0 = dn();
            else begin
              room = 11'(PAGE_BYTES) - 11'(addr_m[PB-1:0]);
              cl_nxt = d.it.length < 25'(room) ? d.it.length[10:0] : room;
              r0 = spi(OP_WREN, 1'b1); ph_nxt = PH_WREN;
            end
          end
          K_ERASE: begin
            if (d.it.length == '0) r0 = dn();
            else begin
              sn_nxt = addr_m >> SB; sf_nxt = endc >> SB;
              ca_nxt = 24'((addr_m >> SB) << SB) & AMASK;
              r0 = spi(OP_WREN, 1'b1); ph_nxt = PH_WREN;
            end
          end
          K_ID: begin
            id_nxt = '0; hi_nxt = '0; r0 = spi(OP_RDID, 1'b0); ph_nxt = PH_ID;
          end
          K_STATUS: begin r0 = spi(OP_RDSR, 1'b0); ph_nxt = PH_STCMD; end
          default: begin r0 = spi(OP_RSTEN, 1'b0); ph_nxt = PH_RSTEN; end
        endcase
      end else if (d.data && ph_r == PH_NEED) begin
        n = 2'd1; r0 = spi(d.it.write_byte, cl_r == 11'd1); ph_nxt = PH_PDATA;
      end else if (d.reply && ph_r != PH_IDLE && ph_r != PH_NEED) begin
        n = 2'd1;
        unique case (ph_r)
          PH_HDR: begin
            if (hi_r + 3'd1 < hlen) begin
              hi_nxt = hi_r + 3'd1;
              r0 = spi(hdr_byte(hi_nxt, op_r, ca_r), hdr_end(hi_nxt, op_r, bl_r));
            end else if (op_r <= K_FREAD) begin
              if (bl_r != '0) begin
                r0 = spi(FILLER, bl_r == 25'd1); ph_nxt = PH_RDATA;
              end else begin r0 = dn(); ph_nxt = PH_IDLE; end
            end else if (op_r == K_PROG) begin
              r0 = nd(); ph_nxt = PH_NEED;
            end else begin r0 = spi(OP_RDSR, 1'b0); ph_nxt = PH_POLLCMD; end
          end
          PH_RDATA: begin
            n = 2'd2; r0 = rd({16'd0, rb});
            bl_nxt = bl_r - 25'd1; ca_nxt = ca_p1;
            if (bl_nxt != '0) r1 = spi(FILLER, bl_nxt == 25'd1);
            else begin r1 = dn(); ph_nxt = PH_IDLE; end
          end
          PH_PDATA: begin
            cl_nxt = cl_r - 11'd1; bl_nxt = bl_r - 25'd1; ca_nxt = ca_p1;
            if (cl_nxt != '0) begin r0 = nd(); ph_nxt = PH_NEED; end
            else begin r0 = spi(OP_RDSR, 1'b0); ph_nxt = PH_POLLCMD; end
          end
          PH_WREN: begin
            hi_nxt = '0; r0 = spi(hdr_byte(3'd0, op_r, ca_r), hdr_end(3'd0, op_r, bl_r));
            ph_nxt = PH_HDR;
          end
          PH_POLLCMD: begin r0 = spi(FILLER, 1'b1); ph_nxt = PH_POLLBYTE; end
          PH_POLLBYTE: begin
            if (rb[0]) begin r0 = spi(OP_RDSR, 1'b0); ph_nxt = PH_POLLCMD; end
            else begin r0 = spi(OP_WRDI, 1'b1); ph_nxt = PH_WRDI; end
          end
          PH_WRDI: begin
            if (op_r == K_PROG && bl_r != '0) begin
              room = 11'(PAGE_BYTES) - 11'(ca_r[PB-1:0]);
              cl_nxt = bl_r < 25'(room) ? bl_r[10:0] : room;
              r0 = spi(OP_WREN, 1'b1); ph_nxt = PH_WREN;
            end else if (op_r == K_ERASE && sn_r < sf_r) begin
              sn_nxt = sn_r + 24'd1;
              room_a = 24'((sn_nxt << SB) & {8'd0, AMASK});
              ca_nxt = room_a;
              r0 = spi(OP_WREN, 1'b1); ph_nxt = PH_WREN;
            end else begin r0 = dn(); ph_nxt = PH_IDLE; end
          end
          PH_ID: begin
            if (hi_r != '0) id_nxt = {id_r[15:0], rb};
            if (hi_r >= 3'd3) begin
              n = 2'd2; r0 = rd(id_nxt); r1 = dn(); ph_nxt = PH_IDLE;
            end else begin
              hi_nxt = hi_r + 3'd1; r0 = spi(FILLER, hi_nxt == 3'd3);
            end
          end
          PH_STCMD: begin r0 = spi(FILLER, 1'b1); ph_nxt = PH_STBYTE; end
          PH_STBYTE: begin n = 2'd2; r0 = rd({16'd0, rb}); r1 = dn(); ph_nxt = PH_IDLE; end
          PH_RSTEN: begin r0 = spi(OP_RST, 1'b1); ph_nxt = PH_RST; end
          PH_RST: begin r0 = dn(); ph_nxt = PH_IDLE; end
          default: n = 2'd0;
        endcase
      end
      if (n == 2'd1) r0.last = 1'b1;
      if (n == 2'd2) r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; op_r <= '0; ca_r <= '0; bl_r <= '0; cl_r <= '0;
      hi_r <= '0; id_r <= '0; sn_r <= '0; sf_r <= '0; oc_r <= '0;
    end else begin
      ph_r <= ph_nxt; op_r <= op_nxt; ca_r <= ca_nxt; bl_r <= bl_nxt; cl_r <= cl_nxt;
      hi_r <= hi_nxt; id_r <= id_nxt; sn_r <= sn_nxt; sf_r <= sf_nxt;
      if (take && n != 2'd0) begin
        oc_r <= n;
        o0_r <= r0;
        o1_r <= r1;
      end else if (out_valid && out_ready) begin
        oc_r <= oc_r - 2'd1;
        o0_r <= o1_r;
      end
    end
  end

endmodule

// File: rtl/spi_nor_flash_command_sequencer_core.sv
// Path: a beat is stored in the input queue, then its result is registered in the result register.
// Throughput: one beat per cycle while results are accepted and each beat causes at most one result;
// a beat with two results holds the sequencer until the first of them is drained.
// The four-entry queue lets input beats land while results stall.
// Reset: synchronous active-low rst_n clears queue, sequencer and outputs to idle.
module spi_nor_flash_command_sequencer_core import snfcs_pkg::*; #(
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096,
  parameter int ADDRESS_BITS = 24
) (
  input logic        clk,
  input logic        rst_n,
  snfcs_in_if.sink   in_ch,
  snfcs_out_if.source out_ch
);

  logic q_valid, q_ready;
  cls_t q_data;

  snfcs_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_ready, .q_data
  );

  snfcs_back #(
    .PAGE_BYTES(PAGE_BYTES), .SECTOR_BYTES(SECTOR_BYTES), .ADDRESS_BITS(ADDRESS_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import snfcs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  snfcs_in_if  in_ch ();
  snfcs_out_if out_ch ();

  spi_nor_flash_command_sequencer_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  localparam int PAGE = 256;
  localparam int SECTOR = 4096;
  localparam logic [23:0] AMASK = 24'hFFFFFF;

  phase_t       seq_phase;
  logic [3:0]   seq_op;
  logic [23:0]  seq_addr;
  logic [24:0]  seq_left;
  logic [8:0]   seq_chunk;
  logic [2:0]   seq_hdr;
  logic [23:0]  seq_id;
  logic [11:0]  seq_sec;
  logic [11:0]  seq_sec_end;

  res_t frame_q[$];
  res_t step_buf[$];
  res_t dir_exp[$];
  int   errors = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   no_idle = 0;
  bit   hold_rx = 0;

  function automatic res_t mk_spi(logic [7:0] b, logic e);
    res_t r;
    r = '0;
    r.spi_valid = 1'b1;
    r.spi_byte = b;
    r.frame_end = e;
    return r;
  endfunction

  function automatic res_t mk_read(logic [23:0] v);
    res_t r;
    r = '0;
    r.read_valid = 1'b1;
    r.read_data = v;
    return r;
  endfunction

  function automatic res_t mk_flag(bit done);
    res_t r;
    r = '0;
    if (done) r.done_res = 1'b1;
    else r.need_data = 1'b1;
    return r;
  endfunction

  function automatic res_t lst(res_t r);
    res_t o;
    o = r;
    o.last = 1'b1;
    return o;
  endfunction

  task automatic push_done();
    step_buf.push_back(mk_flag(1));
    seq_phase = PH_IDLE;
  endtask

  function automatic int hdr_len();
    return (seq_op == K_FREAD) ? 5 : 4;
  endfunction

  task automatic push_header();
    logic [7:0] b;
    logic e;
    e = 1'b0;
    case (seq_hdr)
      3'd0: b = (seq_op == K_READ) ? OP_READ : (seq_op == K_FREAD) ? OP_FREAD :
                (seq_op == K_PROG) ? OP_PROG : OP_ERASE;
      3'd1: b = seq_addr[23:16];
      3'd2: b = seq_addr[15:8];
      3'd3: b = seq_addr[7:0];
      default: b = 8'h00;
    endcase
    if (seq_hdr + 1 == hdr_len()) begin
      if (seq_op == K_ERASE) e = 1'b1;
      else if (seq_op <= K_FREAD && seq_left == 0) e = 1'b1;
    end
    step_buf.push_back(mk_spi(b, e));
    seq_phase = PH_HDR;
  endtask

  task automatic start_wren();
    int room;
    if (seq_op == K_PROG) begin
      room = PAGE - (seq_addr % PAGE);
      seq_chunk = (seq_left < room) ? seq_left[8:0] : room[8:0];
    end else begin
      seq_addr = 24'((32'(seq_sec) * SECTOR) & 32'(AMASK));
    end
    step_buf.push_back(mk_spi(OP_WREN, 1'b1));
    seq_phase = PH_WREN;
  endtask

  task automatic push_poll();
    step_buf.push_back(mk_spi(OP_RDSR, 1'b0));
    seq_phase = PH_POLLCMD;
  endtask

  task automatic predict_reply(logic [7:0] rb);
    case (seq_phase)
      PH_HDR: begin
        if (seq_hdr + 1 < hdr_len()) begin
          seq_hdr++;
          push_header();
        end else if (seq_op <= K_FREAD) begin
          if (seq_left != 0) begin
            step_buf.push_back(mk_spi(FILLER, seq_left == 1));
            seq_phase = PH_RDATA;
          end else push_done();
        end else if (seq_op == K_PROG) begin
          step_buf.push_back(mk_flag(0));
          seq_phase = PH_NEED;
        end else push_poll();
      end
      PH_RDATA: begin
        step_buf.push_back(mk_read({16'h0, rb}));
        seq_left--;
        seq_addr = (seq_addr + 24'd1) & AMASK;
        if (seq_left != 0) step_buf.push_back(mk_spi(FILLER, seq_left == 1));
        else push_done();
      end
      PH_PDATA: begin
        seq_chunk--;
        seq_left--;
        seq_addr = (seq_addr + 24'd1) & AMASK;
        if (seq_chunk != 0) begin
          step_buf.push_back(mk_flag(0));
          seq_phase = PH_NEED;
        end else push_poll();
      end
      PH_WREN: begin
        seq_hdr = 0;
        push_header();
      end
      PH_POLLCMD: begin
        step_buf.push_back(mk_spi(FILLER, 1'b1));
        seq_phase = PH_POLLBYTE;
      end
      PH_POLLBYTE: begin
        if (rb[0]) push_poll();
        else begin
          step_buf.push_back(mk_spi(OP_WRDI, 1'b1));
          seq_phase = PH_WRDI;
        end
      end
      PH_WRDI: begin
        if (seq_op == K_PROG && seq_left != 0) start_wren();
        else if (seq_op == K_ERASE && seq_sec < seq_sec_end) begin
          seq_sec++;
          start_wren();
        end else push_done();
      end
      PH_ID: begin
        if (seq_hdr != 0) seq_id = {seq_id[15:0], rb};
        if (seq_hdr >= 3) begin
          step_buf.push_back(mk_read(seq_id));
          push_done();
        end else begin
          seq_hdr++;
          step_buf.push_back(mk_spi(FILLER, seq_hdr == 3));
        end
      end
      PH_STCMD: begin
        step_buf.push_back(mk_spi(FILLER, 1'b1));
        seq_phase = PH_STBYTE;
      end
      PH_STBYTE: begin
        step_buf.push_back(mk_read({16'h0, rb}));
        push_done();
      end
      PH_RSTEN: begin
        step_buf.push_back(mk_spi(OP_RST, 1'b1));
        seq_phase = PH_RST;
      end
      PH_RST: push_done();
      default: ;
    endcase
  endtask

  task automatic predict_request(item_t it);
    logic [31:0] last_byte;
    seq_op = it.kind;
    case (it.kind)
      K_READ, K_FREAD: begin
        seq_addr = it.address;
        seq_left = it.length;
        seq_hdr = 0;
        push_header();
      end
      K_PROG: begin
        seq_addr = it.address;
        seq_left = it.length;
        if (it.length == 0) push_done();
        else start_wren();
      end
      K_ERASE: begin
        if (it.length == 0) push_done();
        else begin
          last_byte = 32'(it.address) + 32'(it.length) - 1;
          if (last_byte > AMASK) last_byte = AMASK;
          seq_sec = 12'(it.address / SECTOR);
          seq_sec_end = 12'(last_byte / SECTOR);
          start_wren();
        end
      end
      K_ID: begin
        seq_id = 0;
        seq_hdr = 0;
        step_buf.push_back(mk_spi(OP_RDID, 1'b0));
        seq_phase = PH_ID;
      end
      K_STATUS: begin
        step_buf.push_back(mk_spi(OP_RDSR, 1'b0));
        seq_phase = PH_STCMD;
      end
      default: begin
        step_buf.push_back(mk_spi(OP_RSTEN, 1'b0));
        seq_phase = PH_RSTEN;
      end
    endcase
  endtask

  task automatic predict_beat(item_t it);
    res_t r;
    step_buf.delete();
    if (it.kind <= K_RESET) begin
      if (seq_phase == PH_IDLE) predict_request(it);
    end else if (it.kind == K_REPLY) begin
      if (seq_phase != PH_IDLE && seq_phase != PH_NEED) predict_reply(it.reply_byte);
    end else if (it.kind == K_DATA) begin
      if (seq_phase == PH_NEED) begin
        step_buf.push_back(mk_spi(it.write_byte, seq_chunk == 1));
        seq_phase = PH_PDATA;
      end
    end
    if (step_buf.size() > 0) begin
      r = step_buf[$];
      r.last = 1'b1;
      step_buf[$] = r;
    end
    foreach (step_buf[i]) frame_q.push_back(step_buf[i]);
  endtask

  initial begin
    seq_phase = PH_IDLE;
    seq_op = 0; seq_addr = 0; seq_left = 0; seq_chunk = 0;
    seq_hdr = 0; seq_id = 0; seq_sec = 0; seq_sec_end = 0;
  end

  // Scoreboard and watchdog
  always @(posedge clk) begin
    res_t exp_r;
    res_t exp_d;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) predict_beat(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (dir_exp.size() != 0) begin
          exp_d = dir_exp.pop_front();
          if (out_ch.data !== exp_d) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", exp_d, out_ch.data);
          end
        end
        if (frame_q.size() == 0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_ch.data);
        end else begin
          exp_r = frame_q.pop_front();
          if (out_ch.data !== exp_r) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", exp_r, out_ch.data);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_rx = 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Sender
  task automatic send(item_t it);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic item_t mk_item(logic [3:0] k, logic [23:0] a, logic [24:0] l,
                                    logic [7:0] w, logic [7:0] r);
    item_t it;
    it.kind = k; it.address = a; it.length = l; it.write_byte = w; it.reply_byte = r;
    return it;
  endfunction

  function automatic item_t rnd_noise();
    return mk_item(4'($urandom_range(0, 15)), 24'($urandom), 25'($urandom),
                   8'($urandom), 8'($urandom));
  endfunction

  // Answer whatever the sequencer currently waits for, as a well-formed host/flash.
  function automatic item_t rnd_answer();
    logic [7:0] rb;
    rb = 8'($urandom);
    if (seq_phase == PH_POLLBYTE && $urandom_range(0, 2) != 0) rb[0] = 1'b0;
    if (seq_phase == PH_NEED)
      return mk_item(K_DATA, 24'($urandom), 25'($urandom), 8'($urandom), rb);
    return mk_item(K_REPLY, 24'($urandom), 25'($urandom), 8'($urandom), rb);
  endfunction

  function automatic item_t rnd_request();
    logic [23:0] a;
    logic [24:0] l;
    a = 24'($urandom);
    case ($urandom_range(0, 5))
      0: l = 0;
      1: l = 25'($urandom_range(1, 4));
      2: l = 25'($urandom_range(1, 300));
      default: l = 25'($urandom_range(0, 8));
    endcase
    if ($urandom_range(0, 3) == 0) a[7:0] = 8'hFF - 8'($urandom_range(0, 3));
    if ($urandom_range(0, 19) == 0) begin
      a = AMASK - 24'($urandom_range(0, 9000));
      l = 25'h1FFFFFF - 25'($urandom_range(0, 3));
    end
    return mk_item(4'($urandom_range(0, 6)), a, l, 8'($urandom), 8'($urandom));
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  item_t dir_tab[$];

  initial begin
    int n;
    item_t it;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: stray beats after reset, status, reset, zero-length erase, program
    dir_tab = '{
      mk_item(K_REPLY, 0, 0, 0, 8'hFF),
      mk_item(K_DATA, 0, 0, 8'hFF, 0),
      mk_item(4'd15, AMASK, 25'h1FFFFFF, 8'hFF, 8'hFF),
      mk_item(K_STATUS, 0, 0, 0, 0),
      mk_item(K_REPLY, 0, 0, 0, 8'h00),
      mk_item(K_REPLY, 0, 0, 0, 8'hA5),
      mk_item(K_RESET, 0, 0, 0, 0),
      mk_item(K_REPLY, 0, 0, 0, 0),
      mk_item(K_REPLY, 0, 0, 0, 0),
      mk_item(K_ERASE, AMASK, 0, 0, 0),
      mk_item(K_PROG, AMASK, 0, 0, 0)
    };
    dir_exp = '{
      lst(mk_spi(OP_RDSR, 1'b0)),
      lst(mk_spi(FILLER, 1'b1)),
      mk_read(24'hA5),
      lst(mk_flag(1)),
      lst(mk_spi(OP_RSTEN, 1'b0)),
      lst(mk_spi(OP_RST, 1'b1)),
      lst(mk_flag(1)),
      lst(mk_flag(1)),
      lst(mk_flag(1))
    };
    foreach (dir_tab[i]) send(dir_tab[i]);
    wait_drained();

    dir_tab = '{
      mk_item(K_ID, 0, 0, 0, 0),
      mk_item(K_REPLY, 0, 0, 0, 0),
      mk_item(K_REPLY, 0, 0, 0, 8'hEF),
      mk_item(K_REPLY, 0, 0, 0, 8'h40),
      mk_item(K_REPLY, 0, 0, 0, 8'h17),
      mk_item(K_READ, AMASK, 0, 0, 0),
      mk_item(K_FREAD, AMASK, 1, 0, 0),
      mk_item(K_PROG, 24'h0000FF, 2, 0, 0),
      mk_item(K_ERASE, 24'hFFF000, 25'h1FFFFFF, 0, 0),
      mk_item(K_READ, 0, 2, 0, 0)
    };
    foreach (dir_tab[i]) begin
      send(dir_tab[i]);
      if (dir_tab[i].kind <= K_RESET)
        for (int j = 0; j < 40 && seq_phase != PH_IDLE; j++) send(rnd_answer());
    end
    wait_drained();

    // Long receiver hold while the sender keeps offering
    hold_rx = 1;
    send(mk_item(K_READ, 24'h123456, 20, 0, 0));
    for (int j = 0; j < 30; j++) send(rnd_answer());
    wait_drained();

    n = 0;
    while (n < 300) begin
      if (n > 250) no_idle = 1;
      if (seq_phase == PH_IDLE || $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 9) == 0) it = rnd_noise();
        else it = rnd_request();
      end else if ($urandom_range(0, 19) == 0) it = rnd_noise();
      else it = rnd_answer();
      send(it);
      n++;
      if (seq_phase == PH_IDLE && $urandom_range(0, 40) == 0) wait_drained();
    end
    // Finish the running operation so the tail is well-formed
    for (int j = 0; j < 40 && seq_phase != PH_IDLE; j++) send(rnd_answer());
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && frame_q.size() == 0 && dir_exp.size() == 0)
      $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: sim.f
rtl/snfcs_pkg.sv
rtl/snfcs_if.sv
rtl/snfcs_front.sv
rtl/snfcs_back.sv
rtl/spi_nor_flash_command_sequencer_core.sv
bench/tb.sv
